// File: rtl/lsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// Types, constants and field tables of the LNAV subframe decoder.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int unsigned WordW     = 24;
  localparam int unsigned NumWords  = 10;
  localparam int unsigned WaddrW    = 4;
  localparam int unsigned ParamW    = 32;
  localparam int unsigned ParamDep  = 33;
  localparam int unsigned PaddrW    = 6;
  localparam int unsigned TowW      = 20;
  localparam logic [PaddrW-1:0] PendBase  = 6'd24;
  localparam logic [PaddrW-1:0] PubIode   = 6'd7;
  localparam logic [TowW:0]     WeekSecs  = 21'd604800;
  localparam logic [TowW:0]     SfSecs    = 21'd6;
  localparam logic [WaddrW-1:0] LastWord  = 4'd9;

  localparam logic [2:0] KindClock = 3'd1;
  localparam logic [2:0] KindEph1  = 3'd2;
  localparam logic [2:0] KindEph2  = 3'd3;

  localparam logic [4:0] OpClkFirst = 5'd0;
  localparam logic [4:0] OpClkLast  = 5'd6;
  localparam logic [4:0] OpE1First  = 5'd7;
  localparam logic [4:0] OpE1Last   = 5'd15;
  localparam logic [4:0] OpE2First  = 5'd16;
  localparam logic [4:0] OpE2Last   = 5'd23;

  localparam logic [4:0] IdClkFirst = 5'd1;
  localparam logic [4:0] IdClkLast  = 5'd7;
  localparam logic [4:0] IdEphFirst = 5'd8;
  localparam logic [4:0] IdEphLast  = 5'd24;
  localparam logic [4:0] IdNone     = 5'd0;

  typedef enum logic [1:0] {
    OP_PLAIN,
    OP_CAT,
    OP_IODC
  } op_kind_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [WaddrW-1:0]  wa;
    logic [WaddrW-1:0]  wb;
    logic [4:0]         sh;
    logic [4:0]         len;
    logic [PaddrW-1:0]  dst;
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SINGLE,
    S_HDR_RD,
    S_HDR,
    S_OP_A,
    S_OP_B,
    S_OP_W,
    S_CHK_RD,
    S_CHK_P,
    S_CHK_E,
    S_CP_RD,
    S_CP_W,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  function automatic op_t mk(op_kind_e k, logic [3:0] a, logic [3:0] b,
                             logic [4:0] s, logic [4:0] l, logic [5:0] d);
    op_t o;
    o.kind = k; o.wa = a; o.wb = b; o.sh = s; o.len = l; o.dst = d;
    return o;
  endfunction

  function automatic op_t op_rom(logic [4:0] idx);
    op_t o;
    case (idx)
      5'd0:  o = mk(OP_PLAIN, 4'd2, 4'd2, 5'd14, 5'd10, 6'd0);
      5'd1:  o = mk(OP_IODC,  4'd2, 4'd6, 5'd0,  5'd0,  6'd1);
      5'd2:  o = mk(OP_PLAIN, 4'd6, 4'd6, 5'd0,  5'd8,  6'd2);
      5'd3:  o = mk(OP_PLAIN, 4'd7, 4'd7, 5'd0,  5'd16, 6'd3);
      5'd4:  o = mk(OP_PLAIN, 4'd8, 4'd8, 5'd16, 5'd8,  6'd4);
      5'd5:  o = mk(OP_PLAIN, 4'd8, 4'd8, 5'd0,  5'd16, 6'd5);
      5'd6:  o = mk(OP_PLAIN, 4'd9, 4'd9, 5'd2,  5'd22, 6'd6);
      5'd7:  o = mk(OP_PLAIN, 4'd2, 4'd2, 5'd16, 5'd8,  6'd24);
      5'd8:  o = mk(OP_PLAIN, 4'd2, 4'd2, 5'd0,  5'd16, 6'd25);
      5'd9:  o = mk(OP_PLAIN, 4'd3, 4'd3, 5'd8,  5'd16, 6'd26);
      5'd10: o = mk(OP_CAT,   4'd3, 4'd4, 5'd0,  5'd0,  6'd27);
      5'd11: o = mk(OP_PLAIN, 4'd5, 4'd5, 5'd8,  5'd16, 6'd28);
      5'd12: o = mk(OP_CAT,   4'd5, 4'd6, 5'd0,  5'd0,  6'd29);
      5'd13: o = mk(OP_PLAIN, 4'd7, 4'd7, 5'd8,  5'd16, 6'd30);
      5'd14: o = mk(OP_CAT,   4'd7, 4'd8, 5'd0,  5'd0,  6'd31);
      5'd15: o = mk(OP_PLAIN, 4'd9, 4'd9, 5'd8,  5'd16, 6'd32);
      5'd16: o = mk(OP_PLAIN, 4'd2, 4'd2, 5'd8,  5'd16, 6'd16);
      5'd17: o = mk(OP_CAT,   4'd2, 4'd3, 5'd0,  5'd0,  6'd17);
      5'd18: o = mk(OP_PLAIN, 4'd4, 4'd4, 5'd8,  5'd16, 6'd18);
      5'd19: o = mk(OP_CAT,   4'd4, 4'd5, 5'd0,  5'd0,  6'd19);
      5'd20: o = mk(OP_PLAIN, 4'd6, 4'd6, 5'd8,  5'd16, 6'd20);
      5'd21: o = mk(OP_CAT,   4'd6, 4'd7, 5'd0,  5'd0,  6'd21);
      5'd22: o = mk(OP_PLAIN, 4'd8, 4'd8, 5'd0,  5'd24, 6'd22);
      5'd23: o = mk(OP_PLAIN, 4'd9, 4'd9, 5'd2,  5'd14, 6'd23);
      default: o = mk(OP_PLAIN, 4'd0, 4'd0, 5'd0, 5'd0, 6'd0);
    endcase
    return o;
  endfunction

  function automatic logic [5:0] fld_width(logic [4:0] id);
    logic [5:0] w;
    case (id)
      5'd1, 5'd2:                          w = 6'd10;
      5'd3, 5'd5, 5'd8:                    w = 6'd8;
      5'd4, 5'd6, 5'd9, 5'd10, 5'd12,
      5'd14, 5'd16, 5'd17, 5'd19, 5'd21:   w = 6'd16;
      5'd7:                                w = 6'd22;
      5'd23:                               w = 6'd24;
      5'd24:                               w = 6'd14;
      default:                             w = 6'd32;
    endcase
    return w;
  endfunction

  function automatic logic fld_signed(logic [4:0] id);
    logic s;
    case (id)
      5'd1, 5'd2, 5'd4, 5'd8, 5'd13, 5'd15, 5'd16: s = 1'b0;
      default:                                     s = 1'b1;
    endcase
    return s;
  endfunction

  function automatic logic signed [32:0] field_out(logic [4:0] id,
                                                   logic [ParamW-1:0] raw);
    logic [5:0]  w;
    logic [32:0] m;
    logic [32:0] v;
    w = fld_width(id);
    m = (33'd1 << w) - 33'd1;
    v = {1'b0, raw} & m;
    if (fld_signed(id) && v[w - 6'd1]) begin
      v = v | ~m;
    end
    return v;
  endfunction

endpackage

// File: rtl/lsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_in_if / lsd_out_if
// Valid/ready channels for navigation words and decoded results.
// ----------------------------------------------------------------------------
interface lsd_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] word_data;
  logic        word_ok;
  modport source (output valid, word_data, word_ok, input ready);
  modport sink   (input valid, word_data, word_ok, output ready);
endinterface

interface lsd_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         param_id;
  logic signed [32:0] param_value;
  logic               last;
  logic [19:0]        tow_seconds;
  logic               tow_known;
  logic               clock_valid;
  logic               ephemeris_valid;
  logic               subframe_done;
  logic               subframe_dropped;
  logic [2:0]         subframe_kind;
  modport source (output valid, param_id, param_value, last, tow_seconds, tow_known,
                  clock_valid, ephemeris_valid, subframe_done, subframe_dropped,
                  subframe_kind, input ready);
  modport sink   (input valid, param_id, param_value, last, tow_seconds, tow_known,
                  clock_valid, ephemeris_valid, subframe_done, subframe_dropped,
                  subframe_kind, output ready);
endinterface

// File: rtl/lnav_subframe_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnav_subframe_decoder
// Gathers LNAV words into subframes and publishes raw clock/ephemeris fields.
// ----------------------------------------------------------------------------
// One word is taken at a time. A closing word runs a sequencer over the word
// store and the field store, each with a registered read port: each extracted
// field reads its source words and then writes the field store, and each
// published result reads the field store and then loads the output. The next
// word is taken while the last result of the previous word waits at the output.
module lnav_subframe_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsd_in_if.sink        in_i,
  lsd_out_if.source     out_o
);

  lsd_pkg::state_e             state_q, state_d;
  logic [lsd_pkg::WaddrW-1:0]  cnt_q, cnt_d;
  logic                        bad_q, bad_d;
  logic [lsd_pkg::TowW-1:0]    tow_q, tow_d;
  logic                        known_q, known_d;
  logic                        clk_held_q, clk_held_d;
  logic                        eph_held_q, eph_held_d;
  logic                        pend_q, pend_d;
  logic                        done_q, done_d;
  logic                        drop_q, drop_d;
  logic [2:0]                  kind_q, kind_d;
  logic [4:0]                  op_q, op_d;
  logic [3:0]                  k_q, k_d;
  logic [4:0]                  id_q, id_d;
  logic [lsd_pkg::WordW-1:0]   a_q, a_d;
  logic [7:0]                  pend0_q, pend0_d;
  logic                        match_q, match_d;
  logic                        ov_q, ov_d;

  logic [4:0]                  o_id_q, o_id_d;
  logic signed [32:0]          o_val_q, o_val_d;
  logic                        o_last_q, o_last_d;
  logic [lsd_pkg::TowW-1:0]    o_tow_q;
  logic                        o_known_q, o_clk_q, o_eph_q, o_done_q, o_drop_q;
  logic [2:0]                  o_kind_q;
  logic                        load;

  logic                        w_we, w_re;
  logic [lsd_pkg::WaddrW-1:0]  w_raddr;
  logic [lsd_pkg::WordW-1:0]   w_rdata;
  logic                        p_we, p_re;
  logic [lsd_pkg::PaddrW-1:0]  p_waddr, p_raddr;
  logic [lsd_pkg::ParamW-1:0]  p_wdata, p_rdata;

  lsd_pkg::op_t                op;
  logic                        out_free;
  logic                        accept;
  logic [lsd_pkg::TowW:0]      t_sum;
  logic [lsd_pkg::TowW:0]      t_hdr;
  logic [lsd_pkg::WordW-1:0]   lenmask;

  assign op       = lsd_pkg::op_rom(op_q);
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == lsd_pkg::S_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign w_we     = accept;

  lsd_word_ram u_words (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (cnt_q),
    .wdata_i (in_i.word_data),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  lsd_param_ram u_params (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; bad_d = bad_q; tow_d = tow_q;
    known_d = known_q; clk_held_d = clk_held_q; eph_held_d = eph_held_q;
    pend_d = pend_q; done_d = done_q; drop_d = drop_q; kind_d = kind_q;
    op_d = op_q; k_d = k_q; id_d = id_q; a_d = a_q; pend0_d = pend0_q;
    match_d = match_q;
    o_id_d = o_id_q; o_val_d = o_val_q; o_last_d = o_last_q;
    load = 1'b0;
    w_re = 1'b0; w_raddr = op.wa;
    p_we = 1'b0; p_waddr = op.dst; p_wdata = '0;
    p_re = 1'b0; p_raddr = lsd_pkg::PendBase;
    t_sum = {1'b0, tow_q} + lsd_pkg::SfSecs;
    t_hdr = {4'b0, w_rdata[23:7]} * 21'd6;
    lenmask = 24'hFFFFFF >> (5'd24 - op.len);

    case (state_q)
      lsd_pkg::S_IDLE: begin
        if (accept) begin
          done_d = 1'b0; drop_d = 1'b0; kind_d = '0;
          if (cnt_q == lsd_pkg::LastWord) begin
            cnt_d = '0; bad_d = 1'b0; done_d = 1'b1;
            if (bad_q || !in_i.word_ok) begin
              drop_d = 1'b1;
              if (known_q) begin
                tow_d = (t_sum >= lsd_pkg::WeekSecs) ?
                        lsd_pkg::TowW'(t_sum - lsd_pkg::WeekSecs) :
                        lsd_pkg::TowW'(t_sum);
              end
              state_d = lsd_pkg::S_SINGLE;
            end else begin
              state_d = lsd_pkg::S_HDR_RD;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
            bad_d = bad_q || !in_i.word_ok;
            state_d = lsd_pkg::S_SINGLE;
          end
        end
      end
      lsd_pkg::S_SINGLE: begin
        if (out_free) begin
          load = 1'b1; o_id_d = lsd_pkg::IdNone; o_val_d = '0; o_last_d = 1'b1;
          state_d = lsd_pkg::S_IDLE;
        end
      end
      lsd_pkg::S_HDR_RD: begin
        w_re = 1'b1; w_raddr = 4'd1;
        state_d = lsd_pkg::S_HDR;
      end
      lsd_pkg::S_HDR: begin
        tow_d = (t_hdr >= lsd_pkg::WeekSecs) ?
                lsd_pkg::TowW'(t_hdr - lsd_pkg::WeekSecs) : lsd_pkg::TowW'(t_hdr);
        known_d = 1'b1;
        kind_d = w_rdata[4:2];
        case (w_rdata[4:2])
          lsd_pkg::KindClock: begin
            op_d = lsd_pkg::OpClkFirst; state_d = lsd_pkg::S_OP_A;
          end
          lsd_pkg::KindEph1: begin
            op_d = lsd_pkg::OpE1First; state_d = lsd_pkg::S_OP_A;
          end
          lsd_pkg::KindEph2: state_d = lsd_pkg::S_CHK_RD;
          default: state_d = lsd_pkg::S_SINGLE;
        endcase
      end
      lsd_pkg::S_OP_A: begin
        w_re = 1'b1; w_raddr = op.wa;
        state_d = lsd_pkg::S_OP_B;
      end
      lsd_pkg::S_OP_B: begin
        a_d = w_rdata;
        w_re = 1'b1; w_raddr = op.wb;
        state_d = lsd_pkg::S_OP_W;
      end
      lsd_pkg::S_OP_W: begin
        p_we = 1'b1; p_waddr = op.dst;
        case (op.kind)
          lsd_pkg::OP_CAT:  p_wdata = {a_q[7:0], w_rdata};
          lsd_pkg::OP_IODC: p_wdata = {22'b0, a_q[1:0], w_rdata[23:16]};
          default:          p_wdata = {8'b0, (a_q >> op.sh) & lenmask};
        endcase
        op_d = op_q + 5'd1;
        state_d = lsd_pkg::S_OP_A;
        if (kind_q == lsd_pkg::KindClock && op_q == lsd_pkg::OpClkLast) begin
          clk_held_d = 1'b1; id_d = lsd_pkg::IdClkFirst;
          state_d = lsd_pkg::S_EMIT_RD;
        end else if (kind_q == lsd_pkg::KindEph1 && op_q == lsd_pkg::OpE1Last) begin
          pend_d = 1'b1;
          state_d = lsd_pkg::S_SINGLE;
        end else if (op_q == lsd_pkg::OpE2Last) begin
          eph_held_d = 1'b1; id_d = lsd_pkg::IdEphFirst;
          state_d = lsd_pkg::S_EMIT_RD;
        end
      end
      lsd_pkg::S_CHK_RD: begin
        p_re = 1'b1; p_raddr = lsd_pkg::PendBase;
        w_re = 1'b1; w_raddr = lsd_pkg::LastWord;
        state_d = lsd_pkg::S_CHK_P;
      end
      lsd_pkg::S_CHK_P: begin
        pend0_d = p_rdata[7:0];
        match_d = pend_q && (p_rdata == {24'b0, w_rdata[23:16]});
        p_re = 1'b1; p_raddr = lsd_pkg::PubIode;
        state_d = lsd_pkg::S_CHK_E;
      end
      lsd_pkg::S_CHK_E: begin
        if (match_q && (!eph_held_q || p_rdata != {24'b0, pend0_q})) begin
          k_d = '0; state_d = lsd_pkg::S_CP_RD;
        end else begin
          state_d = lsd_pkg::S_SINGLE;
        end
      end
      lsd_pkg::S_CP_RD: begin
        p_re = 1'b1; p_raddr = lsd_pkg::PendBase + {2'b0, k_q};
        state_d = lsd_pkg::S_CP_W;
      end
      lsd_pkg::S_CP_W: begin
        p_we = 1'b1; p_waddr = lsd_pkg::PubIode + {2'b0, k_q}; p_wdata = p_rdata;
        k_d = k_q + 4'd1;
        state_d = lsd_pkg::S_CP_RD;
        if (k_q == 4'd8) begin
          op_d = lsd_pkg::OpE2First; state_d = lsd_pkg::S_OP_A;
        end
      end
      lsd_pkg::S_EMIT_RD: begin
        p_re = 1'b1; p_raddr = {1'b0, id_q - 5'd1};
        state_d = lsd_pkg::S_EMIT_LD;
      end
      lsd_pkg::S_EMIT_LD: begin
        if (out_free) begin
          load = 1'b1;
          o_id_d = id_q;
          o_val_d = lsd_pkg::field_out(id_q, p_rdata);
          o_last_d = (id_q == lsd_pkg::IdClkLast && kind_q == lsd_pkg::KindClock) ||
                     (id_q == lsd_pkg::IdEphLast);
          id_d = id_q + 5'd1;
          state_d = o_last_d ? lsd_pkg::S_IDLE : lsd_pkg::S_EMIT_RD;
        end
      end
      default: state_d = lsd_pkg::S_IDLE;
    endcase

    ov_d = load ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsd_pkg::S_IDLE; cnt_q <= '0; bad_q <= 1'b0; tow_q <= '0;
      known_q <= 1'b0; clk_held_q <= 1'b0; eph_held_q <= 1'b0; pend_q <= 1'b0;
      done_q <= 1'b0; drop_q <= 1'b0; kind_q <= '0; op_q <= '0; k_q <= '0;
      id_q <= '0; match_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; bad_q <= bad_d; tow_q <= tow_d;
      known_q <= known_d; clk_held_q <= clk_held_d; eph_held_q <= eph_held_d;
      pend_q <= pend_d; done_q <= done_d; drop_q <= drop_d; kind_q <= kind_d;
      op_q <= op_d; k_q <= k_d; id_q <= id_d; match_q <= match_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    pend0_q <= pend0_d;
    if (load) begin
      o_id_q <= o_id_d; o_val_q <= o_val_d; o_last_q <= o_last_d;
      o_tow_q <= tow_q; o_known_q <= known_q; o_clk_q <= clk_held_q;
      o_eph_q <= eph_held_q; o_done_q <= done_q; o_drop_q <= drop_q;
      o_kind_q <= drop_q ? 3'd0 : kind_q;
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.param_id         = o_id_q;
  assign out_o.param_value      = o_val_q;
  assign out_o.last             = o_last_q;
  assign out_o.tow_seconds      = o_tow_q;
  assign out_o.tow_known        = o_known_q;
  assign out_o.clock_valid      = o_clk_q;
  assign out_o.ephemeris_valid  = o_eph_q;
  assign out_o.subframe_done    = o_done_q;
  assign out_o.subframe_dropped = o_drop_q;
  assign out_o.subframe_kind    = o_kind_q;

endmodule

// File: rtl/lsd_word_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_word_ram
// Ten-entry store of the words of the subframe being gathered.
// ----------------------------------------------------------------------------
module lsd_word_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [lsd_pkg::WaddrW-1:0]    waddr_i,
  input  logic [lsd_pkg::WordW-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [lsd_pkg::WaddrW-1:0]    raddr_i,
  output logic [lsd_pkg::WordW-1:0]     rdata_o
);

  logic [lsd_pkg::WordW-1:0] mem [lsd_pkg::NumWords];
  logic [lsd_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lsd_param_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_param_ram
// Published fields (entries 0-23) and pending ephemeris (entries 24-32).
// ----------------------------------------------------------------------------
module lsd_param_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [lsd_pkg::PaddrW-1:0]    waddr_i,
  input  logic [lsd_pkg::ParamW-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [lsd_pkg::PaddrW-1:0]    raddr_i,
  output logic [lsd_pkg::ParamW-1:0]    rdata_o
);

  logic [lsd_pkg::ParamW-1:0] mem [lsd_pkg::ParamDep];
  logic [lsd_pkg::ParamW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/lnav_subframe_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnav_subframe_decoder_test
// Self-checking bench for the LNAV subframe decoder. Words go in through a
// bursty valid/ready source and results come out through a stalling sink.
// A built-in decoder model predicts every result. A short table of directed
// words runs first, then random subframes, broken subframes and noise.
// ----------------------------------------------------------------------------
module lnav_subframe_decoder_test;

  localparam int unsigned FldNone = 0;

  typedef struct packed {
    logic [4:0]         id;
    logic signed [32:0] value;
    logic               last;
    logic [19:0]        tow;
    logic               tow_known;
    logic               clk_valid;
    logic               eph_valid;
    logic               done;
    logic               dropped;
    logic [2:0]         kind;
  } nav_res_t;

  typedef struct {
    logic [23:0] data;
    logic        ok;
    logic        has_exp;
    nav_res_t    exp_res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  lsd_in_if  in_ch();
  lsd_out_if out_ch();

  lnav_subframe_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // decoder model state
  logic [23:0] m_words [10];
  int unsigned m_count;
  bit          m_bad;
  logic [19:0] m_tow;
  bit          m_tow_known;
  logic [31:0] m_pub [24];
  logic [31:0] m_pend [9];
  bit          m_pend_ok;
  bit          m_clk_ok;
  bit          m_eph_ok;

  nav_res_t    expected_results[$];
  int          n_errors;
  int          n_reports;
  bit          rx_enable;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] wbits(int n, int start, int len);
    logic [23:0] w;
    logic [31:0] m;
    w = m_words[n];
    m = (len >= 32) ? 32'hffff_ffff : ((32'd1 << len) - 32'd1);
    return ({8'd0, w} >> (24 - (start - 1) - len)) & m;
  endfunction

  function automatic logic [31:0] join32(int hi, int lo);
    return (wbits(hi, 17, 8) << 24) | wbits(lo, 1, 24);
  endfunction

  function automatic logic signed [32:0] widen(int id, logic [31:0] raw);
    int          w;
    bit          sgn;
    logic [32:0] m;
    logic [32:0] v;
    case (id)
      1, 2:                         w = 10;
      3, 5, 8:                      w = 8;
      4, 6, 9, 10, 12, 14, 16, 17,
      19, 21:                       w = 16;
      7:                            w = 22;
      23:                           w = 24;
      24:                           w = 14;
      default:                      w = 32;
    endcase
    sgn = !(id inside {1, 2, 4, 8, 13, 15, 16});
    m = (33'd1 << w) - 33'd1;
    v = {1'b0, raw} & m;
    if (sgn && v[w-1]) begin
      v = v | ~m;
    end
    return v;
  endfunction

  function automatic logic [19:0] week_wrap(logic [20:0] t);
    if (t >= 21'd604800) begin
      t = t - 21'd604800;
    end
    return t[19:0];
  endfunction

  // advance the model by one word and queue the results it causes
  task automatic decode_word(logic [23:0] data, logic ok);
    int       first;
    int       cnt;
    bit       done;
    bit       dropped;
    logic [2:0] kind;
    nav_res_t r;
    int       n;
    first = 0; cnt = 0; done = 0; dropped = 0; kind = 3'd0;
    m_words[m_count] = data;
    if (!ok) m_bad = 1;
    m_count++;
    if (m_count >= 10) begin
      done = 1;
      if (m_bad) begin
        dropped = 1;
        if (m_tow_known) m_tow = week_wrap({1'b0, m_tow} + 21'd6);
      end else begin
        m_tow = week_wrap(21'(wbits(1, 1, 17) * 6));
        m_tow_known = 1;
        kind = 3'(wbits(1, 20, 3));
        if (kind == lsd_pkg::KindClock) begin
          m_pub[0] = wbits(2, 1, 10);
          m_pub[1] = (wbits(2, 23, 2) << 8) | wbits(6, 1, 8);
          m_pub[2] = wbits(6, 17, 8);
          m_pub[3] = wbits(7, 9, 16);
          m_pub[4] = wbits(8, 1, 8);
          m_pub[5] = wbits(8, 9, 16);
          m_pub[6] = wbits(9, 1, 22);
          m_clk_ok = 1;
          first = 1; cnt = 7;
        end else if (kind == lsd_pkg::KindEph1) begin
          m_pend[0] = wbits(2, 1, 8);
          m_pend[1] = wbits(2, 9, 16);
          m_pend[2] = wbits(3, 1, 16);
          m_pend[3] = join32(3, 4);
          m_pend[4] = wbits(5, 1, 16);
          m_pend[5] = join32(5, 6);
          m_pend[6] = wbits(7, 1, 16);
          m_pend[7] = join32(7, 8);
          m_pend[8] = wbits(9, 1, 16);
          m_pend_ok = 1;
        end else if (kind == lsd_pkg::KindEph2) begin
          if (m_pend_ok && m_pend[0] == wbits(9, 1, 8) &&
              (!m_eph_ok || m_pub[7] != m_pend[0])) begin
            for (int k = 0; k < 9; k++) m_pub[7+k] = m_pend[k];
            m_pub[16] = wbits(2, 1, 16);
            m_pub[17] = join32(2, 3);
            m_pub[18] = wbits(4, 1, 16);
            m_pub[19] = join32(4, 5);
            m_pub[20] = wbits(6, 1, 16);
            m_pub[21] = join32(6, 7);
            m_pub[22] = wbits(8, 1, 24);
            m_pub[23] = wbits(9, 9, 14);
            m_eph_ok = 1;
            first = 8; cnt = 17;
          end
        end
      end
      m_count = 0;
      m_bad = 0;
    end
    n = (cnt == 0) ? 1 : cnt;
    for (int k = 0; k < n; k++) begin
      r.id        = (cnt == 0) ? 5'(FldNone) : 5'(first + k);
      r.value     = (cnt == 0) ? 33'sd0 : widen(first + k, m_pub[first + k - 1]);
      r.last      = (k + 1 == n);
      r.tow       = m_tow;
      r.tow_known = m_tow_known;
      r.clk_valid = m_clk_ok;
      r.eph_valid = m_eph_ok;
      r.done      = done;
      r.dropped   = dropped;
      r.kind      = kind;
      expected_results = {expected_results, r};
    end
  endtask

  // source
  int unsigned burst_left;

  task automatic send_word(logic [23:0] data, logic ok);
    while (burst_left == 0) begin
      @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.word_data <= data;
    in_ch.word_ok   <= ok;
    do @(posedge clk_i); while (!in_ch.ready);
    decode_word(data, ok);
    burst_left--;
    if (burst_left == 0 || $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      if (burst_left == 0) burst_left = 0;
      else burst_left = 0;
    end
  endtask

  task automatic send_row(dir_row_t row);
    send_word(row.data, row.ok);
    if (row.has_exp && expected_results[$] !== row.exp_res) begin
      n_errors++;
      $display("directed row mismatch: model %p table %p", expected_results[$],
               row.exp_res);
    end
  endtask

  function automatic logic [23:0] hdr_word(int tow17, int id);
    return {17'(tow17), 2'b00, 3'(id), 2'b00};
  endfunction

  // ten words of one subframe; iode drives the ephemeris match
  task automatic send_subframe(int id, int tow17, logic [7:0] iode, int bad_at);
    logic [23:0] w;
    for (int n = 0; n < 10; n++) begin
      w = 24'($urandom);
      if (n == 1) w = hdr_word(tow17, id);
      if (n == 2 && id == 2) w[23:16] = iode;
      if (n == 9 && id == 3) w[23:16] = iode;
      send_word(w, n != bad_at);
    end
  endtask

  // sink
  always @(posedge clk_i) begin
    nav_res_t got;
    nav_res_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.param_id, out_ch.param_value, out_ch.last, out_ch.tow_seconds,
              out_ch.tow_known, out_ch.clock_valid, out_ch.ephemeris_valid,
              out_ch.subframe_done, out_ch.subframe_dropped, out_ch.subframe_kind};
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_reports < 10) begin
          n_reports++;
          $display("unexpected result %p", got);
        end
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          n_errors++;
          if (n_reports < 10) begin
            n_reports++;
            $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
    end
    if (!rx_enable) out_ch.ready <= 1'b1;
    else begin
      case ($urandom_range(0, 7))
        0, 1:    out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    nav_res_t none_r;
    int       tow17;
    int       cyc;
    logic [7:0] iode;
    n_errors = 0; n_reports = 0; rx_enable = 0; burst_left = 0;
    m_count = 0; m_bad = 0; m_tow = '0; m_tow_known = 0;
    m_pend_ok = 0; m_clk_ok = 0; m_eph_ok = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.word_data = '0;
    in_ch.word_ok = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, a dropped subframe with unknown time, a week wrap
    none_r = '{5'(FldNone), 33'sd0, 1'b1, 20'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0};
    for (int n = 0; n < 10; n++) begin
      row.data = (n % 2) ? 24'hffffff : 24'h000000;
      row.ok = (n != 4);
      row.has_exp = (n < 9);
      row.exp_res = none_r;
      if (n == 9) begin
        row.has_exp = 1;
        row.exp_res = none_r;
        row.exp_res.done = 1;
        row.exp_res.dropped = 1;
      end
      rows = {rows, row};
    end
    // all-ones tow field times 6 lies past a week and wraps
    for (int n = 0; n < 10; n++) begin
      row.data = (n == 1) ? hdr_word(131071, 7) : 24'hffffff;
      row.ok = 1;
      row.has_exp = 0;
      rows = {rows, row};
    end
    foreach (rows[i]) send_row(rows[i]);
    rx_enable = 1;

    send_subframe(1, 0, 8'h00, -1);
    send_subframe(1, 100799, 8'hff, -1);
    send_subframe(0, 100799, 8'h00, 3);
    send_subframe(2, 5, 8'h80, -1);
    send_subframe(3, 6, 8'h80, -1);
    send_subframe(3, 7, 8'h80, -1);
    send_subframe(4, 8, 8'h00, -1);

    // pause until all results are in
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);

    for (int s = 0; s < 28; s++) begin
      tow17 = ($urandom_range(0, 9) == 0) ? 100799 : $urandom_range(0, 131071);
      iode = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      case ($urandom_range(0, 9))
        0:       for (int k = 0; k < $urandom_range(1, 7); k++)
                   send_word(24'($urandom), 1'($urandom));
        1:       send_subframe($urandom_range(0, 7), tow17, iode, $urandom_range(0, 9));
        2, 3:    send_subframe(1, tow17, iode, -1);
        4, 5, 6: send_subframe(2, tow17, iode, -1);
        default: send_subframe(3, tow17, iode, ($urandom_range(0, 7) == 0) ? 0 : -1);
      endcase
    end
    in_ch.valid <= 1'b0;

    cyc = 0;
    while (expected_results.size() != 0 && cyc < 200000) begin
      @(posedge clk_i);
      cyc++;
    end
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
